FILE: hdl/deque_with_linear_search_macros.svh
// assertion macros for the deque with linear search
`ifndef DEQUE_WITH_LINEAR_SEARCH_MACROS_SVH
`define DEQUE_WITH_LINEAR_SEARCH_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define DWLS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dwls check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define DWLS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dwls check failed");

`endif

FILE: hdl/dwls_pkg.sv
// shared types, constants and helpers for the deque with linear search
package dwls_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int OP_W   = 3;
   localparam int VAL_W  = 32;
   localparam int KIND_W = 3;
   localparam int POS_W  = 7;

   // request op codes
   localparam logic [OP_W-1:0] OP_CREATE     = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH     = 3'd3;
   localparam logic [OP_W-1:0] OP_DISPLAY    = 3'd4;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_DONE      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FOUND     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ELEMENT   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] item_value;
      logic                    last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_DISPLAY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic              load;
      logic              update;
      logic              walk_clear;
      logic              walk_step;
      logic              emit;
      logic [KIND_W-1:0] kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            match;
      logic            last_elem;
      logic            out_free;
   } sts_type;

   // ring slot of the element k places behind the head
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] k);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(k);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

FILE: hdl/dwls_ctrl.sv
// controller state machine for the deque with linear search
module dwls_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dwls_pkg::sts_type sts,
   output dwls_pkg::cmd_type cmd,
   output dwls_pkg::state_type state
);
   import dwls_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      is_insert;

   assign is_insert = sts.op inside {OP_CREATE, OP_PUSH_FRONT, OP_PUSH_BACK};
   assign state     = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (is_insert) begin
               if (sts.out_free) state_in = ST_IDLE;
            end else if (sts.op == OP_SEARCH) begin
               if (!sts.empty)        state_in = ST_SEARCH;
               else if (sts.out_free) state_in = ST_IDLE;
            end else if (sts.op == OP_DISPLAY) begin
               if (!sts.empty)        state_in = ST_DISPLAY;
               else if (sts.out_free) state_in = ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if ((sts.match || sts.last_elem) && sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DISPLAY: begin
            if (sts.last_elem && sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.kind  = KIND_DONE;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_EXEC: begin
            if (is_insert) begin
               if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  if (sts.op != OP_CREATE && sts.full) begin
                     cmd.kind = KIND_FULL;
                  end else begin
                     cmd.update = 1'b1;
                  end
               end
            end else if (sts.op == OP_SEARCH || sts.op == OP_DISPLAY) begin
               if (!sts.empty) begin
                  cmd.walk_clear = 1'b1;
               end else if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = (sts.op == OP_SEARCH) ? KIND_NOT_FOUND : KIND_EMPTY;
               end
            end
         end
         ST_SEARCH: begin
            if (sts.match) begin
               cmd.emit = sts.out_free;
               cmd.kind = KIND_FOUND;
            end else if (sts.last_elem) begin
               cmd.emit = sts.out_free;
               cmd.kind = KIND_NOT_FOUND;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_DISPLAY: begin
            cmd.kind = KIND_ELEMENT;
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.walk_step = !sts.last_elem;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: hdl/dwls_datapath.sv
// entry ring, head and count registers, walk index and response register
module dwls_datapath (
   input  logic              clock,
   input  logic              reset,
   input  dwls_pkg::req_type req_payload,
   input  dwls_pkg::cmd_type cmd,
   output dwls_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dwls_pkg::rsp_type rsp_payload
);
   import dwls_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];

   logic [OP_W-1:0]         op_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic [IDX_W-1:0]        head_ff;
   logic [IDX_W-1:0]        head_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [CNT_W-1:0]        walk_ff;
   logic [CNT_W-1:0]        walk_in;
   logic [IDX_W-1:0]        rd_addr;
   logic [VAL_W-1:0]        rd_data_ff;
   logic [IDX_W-1:0]        wr_addr;
   logic                    wr_en;
   logic [POS_W-1:0]        walk_pos;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_payload.op;
         value_ff <= req_payload.value;
      end
   end

   // ring bookkeeping on create and accepted pushes
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_addr  = '0;
      wr_en    = 1'b0;
      if (cmd.update) begin
         case (op_ff)
            OP_CREATE: begin
               head_in  = '0;
               count_in = CNT_W'(1);
               wr_addr  = '0;
               wr_en    = 1'b1;
            end
            OP_PUSH_FRONT: begin
               head_in  = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
               count_in = count_ff + 1'b1;
               wr_addr  = head_in;
               wr_en    = 1'b1;
            end
            OP_PUSH_BACK: begin
               count_in = count_ff + 1'b1;
               wr_addr  = slot_of(head_ff, count_ff);
               wr_en    = 1'b1;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // walk index, read address runs one step ahead so data lines up with walk_ff
   always_comb begin
      walk_in = walk_ff;
      if (cmd.walk_clear) begin
         walk_in = '0;
      end else if (cmd.walk_step) begin
         walk_in = walk_ff + 1'b1;
      end
   end

   assign rd_addr = slot_of(head_ff, walk_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= '0;
      end else begin
         walk_ff <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // status
   assign walk_pos      = POS_W'(SUM_W'(walk_ff) + SUM_W'(1));
   assign sts.op        = op_ff;
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == CNT_W'(DEPTH));
   assign sts.match     = (rd_data_ff == value_ff);
   assign sts.last_elem = ((SUM_W'(walk_ff) + SUM_W'(1)) == SUM_W'(count_ff));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // response register
   always_comb begin
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.kind         = cmd.kind;
         rsp_in.position     = '0;
         rsp_in.item_value   = '0;
         rsp_in.last         = 1'b1;
         case (cmd.kind)
            KIND_FOUND: begin
               rsp_in.position   = walk_pos;
               rsp_in.item_value = value_ff;
            end
            KIND_ELEMENT: begin
               rsp_in.position   = walk_pos;
               rsp_in.item_value = rd_data_ff;
               rsp_in.last       = sts.last_elem;
            end
            default: begin
               rsp_in.last = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/deque_with_linear_search.sv
// top level of the deque with linear search
// A bounded double-ended queue of signed 32-bit values held in a ring of
// DEPTH entries (dwls_pkg::DEPTH, 16 by default) with a head index and a
// count. One request is worked on at a time. Create, push front and push
// back are accepted, then update and respond; a push when full only responds.
// A search examines up to DEPTH entries, stopping at a match; a display
// walks every entry held, each entry giving one response with last set on
// the final one. The walk rate is set by the single read port of the entry
// memory, which gives one entry a cycle while responses are not stalled.
// Response back-pressure holds the block while the output register stays
// stalled with a response due. The response register lets a new request
// be accepted while the previous response still waits. Entries hold no
// defined value until written; only written entries are ever read.
module deque_with_linear_search (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  dwls_pkg::req_type req_payload,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dwls_pkg::rsp_type rsp_payload
);
   import dwls_pkg::*;

   `include "deque_with_linear_search_macros.svh"

   // command and status between controller and datapath
   cmd_type   cmd;
   sts_type   sts;
   state_type state;

   dwls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd),
      .state     (state)
   );

   dwls_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a response is only loaded when the output register can take it
   `DWLS_ASSERT_SAME(a_emit_into_free, cmd.emit, sts.out_free)
   // the walk never steps past the final held entry
   `DWLS_ASSERT_SAME(a_step_in_range, cmd.walk_step, !sts.last_elem && !sts.empty)
   // an accepted request is followed by a busy cycle
   `DWLS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall && state == ST_EXEC)
   // a found response always carries a real position
   `DWLS_ASSERT_SAME(a_found_pos, rsp_valid && rsp_payload.kind == KIND_FOUND, rsp_payload.position != '0)

endmodule
